// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
// Needs a clock named clock and a reset named reset in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check outside reset
`define BTAL_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");

// check at every edge, reset included
`define BTAL_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) else $error("assertion failed");

`endif

// ===== src/btal_pkg.sv =====
// Package of the buddy tree allocator: defaults, codes, state and node types.
// No dependencies.
package btal_pkg;
   localparam int TREE_LEVELS_DEF    = 12;
   localparam int ROOTS_DEF          = 16;
   localparam int MIN_BLOCK_LOG2_DEF = 10;

   localparam int SIZE_W = 32;
   localparam int ADDR_W = 64;
   localparam int STAT_W = 2;
   localparam int RCNT_W = 5;
   localparam int CSR_IDX_W = 2;

   localparam logic [RCNT_W-1:0] ROOT_COUNT_RESET = RCNT_W'(16);

   localparam logic [STAT_W-1:0] STAT_DONE     = 2'd0;
   localparam logic [STAT_W-1:0] STAT_TOO_BIG  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_NO_BLOCK = 2'd2;
   localparam logic [STAT_W-1:0] STAT_BAD_ADDR = 2'd3;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_ROOT_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BASE  = 2'd1;

   typedef struct packed {
      logic mark;
      logic sub;
   } node_word_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_SIZE, ST_AREAD, ST_AEVAL, ST_ADV, ST_MARK, ST_MUP,
      ST_FCHK, ST_FREAD, ST_FEVAL, ST_PREAD, ST_PEVAL, ST_DONE
   } state_type;
endpackage

// ===== src/btal_if.sv =====
// Channel interfaces of the buddy tree allocator: request, response, register write.
// Depends on btal_pkg.
interface btal_req_if;
   logic                       valid;
   logic                       ready;
   logic                       operation;
   logic [btal_pkg::SIZE_W-1:0] request_size;
   logic [btal_pkg::ADDR_W-1:0] release_address;
   modport source (output valid, operation, request_size, release_address, input ready);
   modport sink (input valid, operation, request_size, release_address, output ready);
endinterface

interface btal_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [btal_pkg::STAT_W-1:0] status;
   logic [btal_pkg::ADDR_W-1:0] block_address;
   modport source (output valid, status, block_address, input ready);
   modport sink (input valid, status, block_address, output ready);
endinterface

interface btal_csr_if;
   logic                          valid;
   logic                          ready;
   logic [btal_pkg::CSR_IDX_W-1:0] index;
   logic [btal_pkg::ADDR_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== src/btal_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module btal_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

// ===== src/btal_seq.sv =====
// Sequencer of the buddy tree allocator: clearing pass, tree search, mark and free walks.
// Depends on btal_pkg and btal_if; drives the mark RAM ports.
module btal_seq #(
   parameter int TREE_LEVELS    = btal_pkg::TREE_LEVELS_DEF,
   parameter int ROOTS          = btal_pkg::ROOTS_DEF,
   parameter int MIN_BLOCK_LOG2 = btal_pkg::MIN_BLOCK_LOG2_DEF,
   parameter int AW             = (ROOTS > 1 ? $clog2(ROOTS) : 1) + TREE_LEVELS
) (
   input  logic                         clock,
   input  logic                         reset,
   btal_req_if.sink                     req,
   btal_rsp_if.source                   rsp,
   input  logic [btal_pkg::RCNT_W-1:0]  root_count,
   input  logic [btal_pkg::ADDR_W-1:0]  pool_base,
   output logic                         mem_we,
   output logic [AW-1:0]                mem_waddr,
   output btal_pkg::node_word_type      mem_wdata,
   output logic [AW-1:0]                mem_raddr,
   input  btal_pkg::node_word_type      mem_rdata
);
   import btal_pkg::*;

   localparam int TOP   = MIN_BLOCK_LOG2 + TREE_LEVELS - 1;
   localparam int NW    = TREE_LEVELS;
   localparam int LVW   = $clog2(TREE_LEVELS);
   localparam int RW    = ROOTS > 1 ? $clog2(ROOTS) : 1;
   localparam int RCW   = $clog2(ROOTS + 1);
   localparam int CW    = RCW > RCNT_W ? RCW : RCNT_W;
   localparam int SHW   = $clog2(TOP + 1);
   localparam int DEPTH = ROOTS << TREE_LEVELS;
   localparam logic [AW-1:0]     CLR_LAST = AW'(DEPTH - 1);
   localparam logic [NW-1:0]     NODE_ONE = NW'(1);
   localparam logic [LVW-1:0]    LV_LEAF  = LVW'(TREE_LEVELS - 1);
   localparam logic [CW-1:0]     ROOTS_C  = CW'(ROOTS);
   localparam logic [ADDR_W:0]   TOP_SIZE = (ADDR_W+1)'(1) << TOP;

   state_type            state_ff, state_in;
   logic [SIZE_W-1:0]    size_ff, size_in;
   logic [ADDR_W-1:0]    addr_ff, addr_in;
   logic [LVW-1:0]       lvl_ff, lvl_in;
   logic [LVW-1:0]       lv_ff, lv_in;
   logic [NW-1:0]        node_ff, node_in;
   logic [RCW-1:0]       root_ff, root_in;
   logic [STAT_W-1:0]    stat_ff, stat_in;
   logic [ADDR_W-1:0]    res_ff, res_in;
   logic [AW-1:0]        clr_ff, clr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]    rsp_stat_ff, rsp_stat_in;
   logic [ADDR_W-1:0]    rsp_addr_ff, rsp_addr_in;

   logic [CW-1:0]        roots_used;
   logic [ADDR_W-1:0]    diff;
   logic [ADDR_W:0]      thr;
   logic [SHW-1:0]       thr_sh;
   logic [NW-1:0]        parent;
   logic [ADDR_W-1:0]    blk_off;

   assign roots_used = (CW'(root_count) > ROOTS_C) ? ROOTS_C : CW'(root_count);
   assign diff       = addr_ff - pool_base;
   assign thr_sh     = SHW'(TOP - 1) - SHW'(lvl_ff);
   assign thr        = (ADDR_W+1)'(1) << thr_sh;
   assign parent     = node_ff >> 1;
   assign blk_off    = (ADDR_W'(root_ff) << TOP)
                     | (ADDR_W'(node_ff ^ (NODE_ONE << lvl_ff)) << (SHW'(TOP) - SHW'(lvl_ff)));

   assign req.ready     = (state_ff == ST_IDLE);
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.status    = rsp_stat_ff;
   assign rsp.block_address = rsp_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      size_ff     <= size_in;
      addr_ff     <= addr_in;
      lvl_ff      <= lvl_in;
      lv_ff       <= lv_in;
      node_ff     <= node_in;
      root_ff     <= root_in;
      stat_ff     <= stat_in;
      res_ff      <= res_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_addr_ff <= rsp_addr_in;
   end

   always_comb begin
      state_in     = state_ff;
      size_in      = size_ff;
      addr_in      = addr_ff;
      lvl_in       = lvl_ff;
      lv_in        = lv_ff;
      node_in      = node_ff;
      root_in      = root_ff;
      stat_in      = stat_ff;
      res_in       = res_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_stat_in  = rsp_stat_ff;
      rsp_addr_in  = rsp_addr_ff;
      mem_we       = 1'b0;
      mem_waddr    = {root_ff[RW-1:0], node_ff};
      mem_wdata    = '{mark: 1'b0, sub: 1'b0};
      mem_raddr    = {root_ff[RW-1:0], node_ff};

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req.valid) begin
               size_in = req.request_size;
               addr_in = req.release_address;
               res_in  = '0;
               lvl_in  = '0;
               stat_in = STAT_DONE;
               if (req.operation == OP_FREE) begin
                  state_in = ST_FCHK;
               end else if ((ADDR_W+1)'(req.request_size) > TOP_SIZE) begin
                  stat_in  = STAT_TOO_BIG;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SIZE;
               end
            end
         end
         ST_SIZE: begin
            if ((lvl_ff != LV_LEAF) && (thr >= (ADDR_W+1)'(size_ff))) begin
               lvl_in = lvl_ff + LVW'(1);
            end else if (roots_used == '0) begin
               stat_in  = STAT_NO_BLOCK;
               state_in = ST_DONE;
            end else begin
               root_in  = '0;
               node_in  = NODE_ONE;
               lv_in    = '0;
               state_in = ST_AREAD;
            end
         end
         ST_AREAD: begin
            state_in = ST_AEVAL;
         end
         ST_AEVAL: begin
            if (mem_rdata.mark) begin
               state_in = ST_ADV;
            end else if (!mem_rdata.sub) begin
               node_in  = node_ff << (lvl_ff - lv_ff);
               state_in = ST_MARK;
            end else if (lv_ff == lvl_ff) begin
               state_in = ST_ADV;
            end else begin
               node_in  = node_ff << 1;
               lv_in    = lv_ff + LVW'(1);
               state_in = ST_AREAD;
            end
         end
         ST_ADV: begin
            if (node_ff == NODE_ONE) begin
               root_in = root_ff + RCW'(1);
               if (CW'(root_ff) + CW'(1) == roots_used) begin
                  stat_in  = STAT_NO_BLOCK;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_AREAD;
               end
            end else if (node_ff[0]) begin
               node_in = parent;
               lv_in   = lv_ff - LVW'(1);
            end else begin
               node_in  = node_ff + NODE_ONE;
               state_in = ST_AREAD;
            end
         end
         ST_MARK: begin
            mem_we    = 1'b1;
            mem_wdata = '{mark: 1'b1, sub: 1'b1};
            res_in    = pool_base + blk_off;
            state_in  = (node_ff == NODE_ONE) ? ST_DONE : ST_MUP;
         end
         ST_MUP: begin
            mem_we    = 1'b1;
            mem_waddr = {root_ff[RW-1:0], parent};
            mem_wdata = '{mark: 1'b0, sub: 1'b1};
            node_in   = parent;
            if (parent == NODE_ONE) begin
               state_in = ST_DONE;
            end
         end
         ST_FCHK: begin
            root_in = RCW'(diff >> TOP);
            node_in = {1'b1, diff[TOP-1:MIN_BLOCK_LOG2]};
            lv_in   = LV_LEAF;
            if ((addr_ff == '0) || (addr_ff < pool_base)
                || ((diff >> TOP) >= ADDR_W'(ROOTS))
                || (diff[MIN_BLOCK_LOG2-1:0] != '0)) begin
               stat_in  = STAT_BAD_ADDR;
               state_in = ST_DONE;
            end else begin
               state_in = ST_FREAD;
            end
         end
         ST_FREAD: begin
            state_in = ST_FEVAL;
         end
         ST_FEVAL: begin
            if (mem_rdata.mark) begin
               mem_we   = 1'b1;
               state_in = (node_ff == NODE_ONE) ? ST_DONE : ST_PREAD;
            end else if ((lv_ff == '0) || node_ff[0]) begin
               stat_in  = STAT_BAD_ADDR;
               state_in = ST_DONE;
            end else begin
               node_in  = parent;
               lv_in    = lv_ff - LVW'(1);
               state_in = ST_FREAD;
            end
         end
         ST_PREAD: begin
            mem_raddr = {root_ff[RW-1:0], node_ff ^ NODE_ONE};
            state_in  = ST_PEVAL;
         end
         ST_PEVAL: begin
            if (mem_rdata.sub) begin
               state_in = ST_DONE;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = {root_ff[RW-1:0], parent};
               node_in   = parent;
               state_in  = (parent == NODE_ONE) ? ST_DONE : ST_PREAD;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_stat_in  = stat_ff;
               rsp_addr_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule

// ===== src/buddy_tree_allocator_unit.sv =====
// Buddy tree allocator over ROOTS trees of 2^(MIN_BLOCK_LOG2+TREE_LEVELS-1) bytes. After reset
// the block sweeps the mark RAM, one node a cycle, through all ROOTS*2^TREE_LEVELS nodes (65536
// by default) before it takes its first item; register writes are taken throughout. One item at a
// time: an allocate rounds the size to a level, runs a depth-first search through the single read
// port of the mark RAM, then marks the block and its ancestors; a free walks up the levels to the
// marked node and then repairs the summaries of its ancestors.
// Depends on btal_pkg, btal_if, btal_ram and btal_seq.
module buddy_tree_allocator_unit #(
   parameter int TREE_LEVELS    = btal_pkg::TREE_LEVELS_DEF,
   parameter int ROOTS          = btal_pkg::ROOTS_DEF,
   parameter int MIN_BLOCK_LOG2 = btal_pkg::MIN_BLOCK_LOG2_DEF
) (
   input logic          clock,
   input logic          reset,
   btal_req_if.sink     req_ch,
   btal_rsp_if.source   rsp_ch,
   btal_csr_if.sink     csr_ch
);
   import btal_pkg::*;

   localparam int AW = (ROOTS > 1 ? $clog2(ROOTS) : 1) + TREE_LEVELS;

   logic [RCNT_W-1:0] root_count_ff;
   logic [ADDR_W-1:0] pool_base_ff;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [AW-1:0]     mem_raddr;
   node_word_type     mem_wdata;
   node_word_type     mem_rdata;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         root_count_ff <= ROOT_COUNT_RESET;
         pool_base_ff  <= '0;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_ROOT_COUNT: root_count_ff <= csr_ch.data[RCNT_W-1:0];
            CSR_POOL_BASE:  pool_base_ff  <= csr_ch.data;
            default: begin
            end
         endcase
      end
   end

   btal_seq #(
      .TREE_LEVELS    (TREE_LEVELS),
      .ROOTS          (ROOTS),
      .MIN_BLOCK_LOG2 (MIN_BLOCK_LOG2),
      .AW             (AW)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .root_count (root_count_ff),
      .pool_base  (pool_base_ff),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata)
   );

   btal_ram #(
      .WIDTH ($bits(node_word_type)),
      .DEPTH (ROOTS << TREE_LEVELS)
   ) u_marks (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );
endmodule

// ===== src/btal_chk.sv =====
// Port checker of the buddy tree allocator, bound to the top level.
// Depends on btal_pkg and assert_macros.svh.
`include "assert_macros.svh"
module btal_chk (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [btal_pkg::STAT_W-1:0] rsp_status,
   input logic [btal_pkg::ADDR_W-1:0] rsp_block_address
);
   import btal_pkg::*;

   `BTAL_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid)
   `BTAL_ASSERT(a_busy_after_item, req_valid && req_ready |=> !req_ready)
   `BTAL_ASSERT(a_fail_no_addr, rsp_valid && (rsp_status != STAT_DONE) |-> rsp_block_address == '0)
   `BTAL_ASSERT_ALWAYS(a_clear_after_reset, $past(reset) && !reset |-> !req_ready)
endmodule

bind buddy_tree_allocator_unit btal_chk u_chk (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_status        (rsp_ch.status),
   .rsp_block_address (rsp_ch.block_address)
);
